// ===== hw/rtl/bba_pkg.sv =====
// Package for the buddy block allocator: sizes, item types, status codes
// and state encoding. No dependencies.
`default_nettype none
package bba_pkg;
    localparam int POOL_SHIFT = 12;
    localparam int MIN_SHIFT  = 4;
    localparam int LEVEL_SPAN = POOL_SHIFT - MIN_SHIFT;
    localparam int UNIT_COUNT = 1 << LEVEL_SPAN;
    localparam int ROW_COUNT  = LEVEL_SPAN + 1;
    localparam int ROW_W      = UNIT_COUNT;
    localparam int POS_W      = LEVEL_SPAN;
    localparam int DEPTH_W    = $clog2(ROW_COUNT);
    localparam int ORDER_W    = 4;
    localparam int OFF_W      = 12;
    localparam int REQ_W      = 13;
    localparam int USED_W     = 13;

    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_FREE    = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic             op;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] block_offset;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [OFF_W-1:0]   granted_offset;
        logic [ORDER_W-1:0] block_order;
        logic [USED_W-1:0]  bytes_in_use;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SPLIT,
        S_ORDER,
        S_MERGE
    } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/buddy_block_allocator.sv =====
// Buddy block allocator top level: control sequencer, free-tree row memory,
// order memory and valid bits. Depends on bba_pkg.
//
// Usage: present an item on cmd with start high while busy is low; the item
// is taken at that edge. One result per item appears on result for exactly
// one cycle with done high; it cannot be held off.
// A failed allocate (zero or oversize request) and a misaligned or unowned
// free finish in the accepting cycle: done is high in the next cycle and
// busy stays low, so a new item may follow every cycle.
// An allocate reads one free-tree row per cycle, walking up from the
// requested order to the first level holding a free block, then writes one
// row per cycle walking back down while splitting (at most nine rows up,
// eight rows down). A free reads the order memory, then merges one level
// per cycle. The next item may be taken in the cycle that done is high.
// The free tree is a 9-row memory of 256-bit rows, one row per level,
// with a registered read and a separate write port; the registered read
// sets the per-level pace.
// Reset empties the pool at once: per-row valid bits make untouched rows
// read as all busy except the root, which reads as free. No clearing pass.
`default_nettype none
module buddy_block_allocator (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire bba_pkg::cmd_t    cmd,
    output logic                  busy,
    output logic                  done,
    output bba_pkg::result_t      result
);
    localparam int PW = bba_pkg::POS_W;
    localparam int DW = bba_pkg::DEPTH_W;
    localparam int KW = bba_pkg::ORDER_W;
    localparam int REQ_W1 = bba_pkg::REQ_W + 1;

    logic [bba_pkg::ROW_W-1:0]   tree_mem [bba_pkg::ROW_COUNT];
    logic [bba_pkg::ROW_W-1:0]   tree_q;
    logic [DW-1:0]               row_q;
    logic [bba_pkg::ROW_COUNT-1:0] row_valid_reg, row_valid_next;
    logic [KW-1:0]               order_mem [bba_pkg::UNIT_COUNT];
    logic [KW-1:0]               order_q;
    logic [bba_pkg::UNIT_COUNT-1:0] unit_valid_reg, unit_valid_next;

    bba_pkg::state_t             state_reg, state_next;
    logic [DW-1:0]               d_reg, d_next;
    logic [DW-1:0]               td_reg, td_next;
    logic [PW-1:0]               pos_reg, pos_next;
    logic [KW-1:0]               k_reg, k_next;
    logic [bba_pkg::OFF_W-1:0]   off_reg, off_next;
    logic [bba_pkg::USED_W-1:0]  used_reg, used_next;
    bba_pkg::result_t            res_reg, res_next;
    logic                        done_reg, done_next;

    logic                        rd_en;
    logic [DW-1:0]               rd_addr;
    logic                        wr_en;
    logic [DW-1:0]               wr_addr;
    logic [bba_pkg::ROW_W-1:0]   wr_data;
    logic                        ord_wr;
    logic                        ord_rd;
    logic [PW-1:0]               ord_addr;

    logic [bba_pkg::ROW_W-1:0]   row_data;
    logic [PW-1:0]               low_idx;
    logic [KW-1:0]               req_k;
    logic [PW-1:0]               unit_in;
    logic [PW-1:0]               unit_reg_idx;

    function automatic logic [PW-1:0] lowest_set(input logic [bba_pkg::ROW_W-1:0] v);
        logic [PW-1:0] idx;
        idx = '0;
        for (int i = bba_pkg::ROW_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = PW'(i);
            end
        end
        return idx;
    endfunction

    always_comb
    begin
        req_k = KW'(bba_pkg::POOL_SHIFT + 1);
        for (int i = bba_pkg::POOL_SHIFT; i >= 0; i--)
        begin
            if ((REQ_W1'(1) << i) >= REQ_W1'(cmd.request_bytes))
            begin
                req_k = KW'(i);
            end
        end
        if (req_k < KW'(bba_pkg::MIN_SHIFT))
        begin
            req_k = KW'(bba_pkg::MIN_SHIFT);
        end
    end

    assign row_data = row_valid_reg[row_q] ? tree_q :
                      ((row_q == '0) ? bba_pkg::ROW_W'(1) : '0);
    assign low_idx      = lowest_set(row_data);
    assign unit_in      = cmd.block_offset[bba_pkg::OFF_W-1:bba_pkg::MIN_SHIFT];
    assign unit_reg_idx = off_reg[bba_pkg::OFF_W-1:bba_pkg::MIN_SHIFT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tree_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            tree_q <= tree_mem[rd_addr];
            row_q  <= rd_addr;
        end
        if (ord_wr)
        begin
            order_mem[ord_addr] <= k_reg;
        end
        if (ord_rd)
        begin
            order_q <= order_mem[ord_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bba_pkg::S_IDLE;
            row_valid_reg  <= '0;
            unit_valid_reg <= '0;
            used_reg       <= '0;
            done_reg       <= 1'b0;
            d_reg          <= '0;
            td_reg         <= '0;
            pos_reg        <= '0;
            k_reg          <= '0;
            off_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_valid_reg  <= row_valid_next;
            unit_valid_reg <= unit_valid_next;
            used_reg       <= used_next;
            done_reg       <= done_next;
            d_reg          <= d_next;
            td_reg         <= td_next;
            pos_reg        <= pos_next;
            k_reg          <= k_next;
            off_reg        <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        d_next          = d_reg;
        td_next         = td_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        off_next        = off_reg;
        used_next       = used_reg;
        unit_valid_next = unit_valid_reg;
        row_valid_next  = row_valid_reg;
        res_next        = res_reg;
        done_next       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = d_reg;
        wr_en           = 1'b0;
        wr_addr         = d_reg;
        wr_data         = row_data;
        ord_wr          = 1'b0;
        ord_rd          = 1'b0;
        ord_addr        = unit_reg_idx;

        case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    off_next = cmd.block_offset;
                    if (cmd.op == bba_pkg::OP_ALLOC)
                    begin
                        if (cmd.request_bytes == '0 ||
                            req_k > KW'(bba_pkg::POOL_SHIFT))
                        begin
                            done_next = 1'b1;
                            res_next  = '{bba_pkg::ST_NOSPACE, '0, '0, used_reg};
                        end
                        else
                        begin
                            k_next     = req_k;
                            td_next    = DW'(KW'(bba_pkg::POOL_SHIFT) - req_k);
                            d_next     = DW'(KW'(bba_pkg::POOL_SHIFT) - req_k);
                            rd_en      = 1'b1;
                            rd_addr    = DW'(KW'(bba_pkg::POOL_SHIFT) - req_k);
                            state_next = bba_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        if (cmd.block_offset[bba_pkg::MIN_SHIFT-1:0] != '0 ||
                            !unit_valid_reg[unit_in])
                        begin
                            done_next = 1'b1;
                            res_next  = '{bba_pkg::ST_BADFREE, '0, '0, used_reg};
                        end
                        else
                        begin
                            ord_rd     = 1'b1;
                            ord_addr   = unit_in;
                            state_next = bba_pkg::S_ORDER;
                        end
                    end
                end
            end

            bba_pkg::S_SCAN:
            begin
                if (row_data != '0)
                begin
                    wr_en   = 1'b1;
                    wr_data = row_data & ~(bba_pkg::ROW_W'(1) << low_idx);
                    row_valid_next[d_reg] = 1'b1;
                    if (d_reg == td_reg)
                    begin
                        off_next = bba_pkg::OFF_W'(low_idx) << k_reg;
                        ord_wr   = 1'b1;
                        ord_addr = PW'((bba_pkg::OFF_W'(low_idx) << k_reg)
                                       >> bba_pkg::MIN_SHIFT);
                        unit_valid_next[PW'((bba_pkg::OFF_W'(low_idx) << k_reg)
                                       >> bba_pkg::MIN_SHIFT)] = 1'b1;
                        used_next  = used_reg + (bba_pkg::USED_W'(1) << k_reg);
                        done_next  = 1'b1;
                        res_next   = '{bba_pkg::ST_OK,
                                       bba_pkg::OFF_W'(low_idx) << k_reg,
                                       k_reg, used_next};
                        state_next = bba_pkg::S_IDLE;
                    end
                    else
                    begin
                        pos_next   = low_idx << 1;
                        d_next     = d_reg + DW'(1);
                        rd_en      = 1'b1;
                        rd_addr    = d_reg + DW'(1);
                        state_next = bba_pkg::S_SPLIT;
                    end
                end
                else if (d_reg == '0)
                begin
                    done_next  = 1'b1;
                    res_next   = '{bba_pkg::ST_NOSPACE, '0, '0, used_reg};
                    state_next = bba_pkg::S_IDLE;
                end
                else
                begin
                    d_next  = d_reg - DW'(1);
                    rd_en   = 1'b1;
                    rd_addr = d_reg - DW'(1);
                end
            end

            bba_pkg::S_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_data = row_data | (bba_pkg::ROW_W'(1) << (pos_reg | PW'(1)));
                row_valid_next[d_reg] = 1'b1;
                if (d_reg == td_reg)
                begin
                    off_next   = bba_pkg::OFF_W'(pos_reg) << k_reg;
                    ord_wr     = 1'b1;
                    ord_addr   = PW'((bba_pkg::OFF_W'(pos_reg) << k_reg)
                                     >> bba_pkg::MIN_SHIFT);
                    unit_valid_next[PW'((bba_pkg::OFF_W'(pos_reg) << k_reg)
                                     >> bba_pkg::MIN_SHIFT)] = 1'b1;
                    used_next  = used_reg + (bba_pkg::USED_W'(1) << k_reg);
                    done_next  = 1'b1;
                    res_next   = '{bba_pkg::ST_OK,
                                   bba_pkg::OFF_W'(pos_reg) << k_reg,
                                   k_reg, used_next};
                    state_next = bba_pkg::S_IDLE;
                end
                else
                begin
                    pos_next = pos_reg << 1;
                    d_next   = d_reg + DW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = d_reg + DW'(1);
                end
            end

            bba_pkg::S_ORDER:
            begin
                if (order_q < KW'(bba_pkg::MIN_SHIFT) ||
                    order_q > KW'(bba_pkg::POOL_SHIFT))
                begin
                    done_next  = 1'b1;
                    res_next   = '{bba_pkg::ST_BADFREE, '0, '0, used_reg};
                    state_next = bba_pkg::S_IDLE;
                end
                else
                begin
                    k_next     = order_q;
                    unit_valid_next[unit_reg_idx] = 1'b0;
                    used_next  = used_reg - (bba_pkg::USED_W'(1) << order_q);
                    d_next     = DW'(KW'(bba_pkg::POOL_SHIFT) - order_q);
                    pos_next   = PW'(off_reg >> order_q);
                    rd_en      = 1'b1;
                    rd_addr    = DW'(KW'(bba_pkg::POOL_SHIFT) - order_q);
                    state_next = bba_pkg::S_MERGE;
                end
            end

            bba_pkg::S_MERGE:
            begin
                wr_en = 1'b1;
                row_valid_next[d_reg] = 1'b1;
                if (d_reg != '0 && row_data[pos_reg ^ PW'(1)])
                begin
                    wr_data  = row_data & ~(bba_pkg::ROW_W'(1) << (pos_reg ^ PW'(1)));
                    pos_next = pos_reg >> 1;
                    d_next   = d_reg - DW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = d_reg - DW'(1);
                end
                else
                begin
                    wr_data    = row_data | (bba_pkg::ROW_W'(1) << pos_reg);
                    done_next  = 1'b1;
                    res_next   = '{bba_pkg::ST_OK, '0, k_reg, used_reg};
                    state_next = bba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != bba_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.bytes_in_use <= bba_pkg::USED_W'(1 << bba_pkg::POOL_SHIFT))
        else $error("bytes in use beyond pool");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != bba_pkg::ST_OK |->
            result.granted_offset == '0 && result.block_order == '0)
        else $error("failed item carries offset or order");
    a_ok_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == bba_pkg::ST_OK |->
            result.block_order >= KW'(bba_pkg::MIN_SHIFT) &&
            result.block_order <= KW'(bba_pkg::POOL_SHIFT))
        else $error("granted order out of range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still working");
endmodule
`default_nettype wire

// ===== sim/tb_buddy_block_allocator.sv =====
// Testbench for the buddy block allocator: directed and random allocate/free
// items checked against an in-bench buddy tree predictor.
// Depends on bba_pkg and buddy_block_allocator.
`default_nettype none
module tb_buddy_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 2 * bba_pkg::UNIT_COUNT;
    localparam int WATCH_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    bba_pkg::cmd_t cmd = '0;
    logic busy;
    logic done;
    bba_pkg::result_t result;

    bit tree_free [NODES];
    logic [bba_pkg::ORDER_W-1:0] unit_order [bba_pkg::UNIT_COUNT];
    bit unit_valid [bba_pkg::UNIT_COUNT];
    logic [bba_pkg::USED_W-1:0] used_bytes;

    bba_pkg::result_t pending_q [$];
    logic [bba_pkg::OFF_W-1:0] owned_q [$];
    int errors = 0;
    int idle_pct = 0;
    int items_sent = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    buddy_block_allocator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .busy(busy), .done(done), .result(result)
    );

    always #5 clk = ~clk;

    function automatic bba_pkg::result_t predict_item(input bba_pkg::cmd_t c);
        bba_pkg::result_t r;
        int k;
        int unit;
        int node;
        int off;
        int lvl;
        r = '0;
        if (c.op == bba_pkg::OP_ALLOC)
        begin
            r.status = bba_pkg::ST_NOSPACE;
            k = bba_pkg::MIN_SHIFT;
            while (k < 14 && (1 << k) < int'(c.request_bytes))
                k++;
            if (c.request_bytes != '0 && k <= bba_pkg::POOL_SHIFT)
            begin
                for (int j = k; j <= bba_pkg::POOL_SHIFT && r.status != bba_pkg::ST_OK; j++)
                begin
                    for (int n = 1 << (bba_pkg::POOL_SHIFT - j);
                         n < 2 << (bba_pkg::POOL_SHIFT - j); n++)
                    begin
                        if (tree_free[n] && r.status != bba_pkg::ST_OK)
                        begin
                            node = n;
                            lvl = j;
                            tree_free[node] = 1'b0;
                            while (lvl > k)
                            begin
                                tree_free[2 * node + 1] = 1'b1;
                                node = 2 * node;
                                lvl--;
                            end
                            off = (node - (1 << (bba_pkg::POOL_SHIFT - k))) << k;
                            unit = off >> bba_pkg::MIN_SHIFT;
                            unit_order[unit] = bba_pkg::ORDER_W'(k);
                            unit_valid[unit] = 1'b1;
                            used_bytes = used_bytes + bba_pkg::USED_W'(1 << k);
                            r.status = bba_pkg::ST_OK;
                            r.granted_offset = bba_pkg::OFF_W'(off);
                            r.block_order = bba_pkg::ORDER_W'(k);
                            owned_q.push_back(bba_pkg::OFF_W'(off));
                        end
                    end
                end
            end
        end
        else
        begin
            r.status = bba_pkg::ST_BADFREE;
            unit = int'(c.block_offset >> bba_pkg::MIN_SHIFT);
            if (c.block_offset[bba_pkg::MIN_SHIFT-1:0] == '0 && unit_valid[unit])
            begin
                k = int'(unit_order[unit]);
                unit_valid[unit] = 1'b0;
                used_bytes = used_bytes - bba_pkg::USED_W'(1 << k);
                node = (1 << (bba_pkg::POOL_SHIFT - k)) + int'(c.block_offset >> k);
                while (node > 1 && tree_free[node ^ 1])
                begin
                    tree_free[node ^ 1] = 1'b0;
                    node = node >> 1;
                end
                tree_free[node] = 1'b1;
                r.status = bba_pkg::ST_OK;
                r.block_order = bba_pkg::ORDER_W'(k);
                for (int i = 0; i < owned_q.size(); i++)
                begin
                    if (owned_q[i] == c.block_offset)
                    begin
                        owned_q.delete(i);
                        break;
                    end
                end
            end
        end
        r.bytes_in_use = used_bytes;
        return r;
    endfunction

    task automatic send_item(input logic op, input int req, input int off);
        bba_pkg::cmd_t c;
        bba_pkg::cmd_t junk;
        c.op = op;
        c.request_bytes = bba_pkg::REQ_W'(req);
        c.block_offset = bba_pkg::OFF_W'(off);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            junk.op = 1'($urandom);
            junk.request_bytes = bba_pkg::REQ_W'($urandom);
            junk.block_offset = bba_pkg::OFF_W'($urandom);
            start <= 1'b0;
            cmd <= junk;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_q.push_back(predict_item(c));
        items_sent++;
    endtask

    task automatic alloc_item(input int req);
        send_item(bba_pkg::OP_ALLOC, req, int'($urandom_range(4095)));
    endtask

    task automatic free_item(input int off);
        send_item(bba_pkg::OP_FREE, int'($urandom_range(8191)), off);
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                errors++;
            end
            else
            begin
                bba_pkg::result_t e;
                e = pending_q.pop_front();
                if (result.status != e.status || result.granted_offset != e.granted_offset ||
                    result.block_order != e.block_order ||
                    result.bytes_in_use != e.bytes_in_use)
                begin
                    $display("%0t: mismatch expected st=%0d off=%0d ord=%0d used=%0d",
                        $time, e.status, e.granted_offset, e.block_order, e.bytes_in_use);
                    $display("%0t:          actual st=%0d off=%0d ord=%0d used=%0d",
                        $time, result.status, result.granted_offset, result.block_order,
                        result.bytes_in_use);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        alloc_item(0);
        alloc_item(4097);
        alloc_item(8191);
        alloc_item(1);
        alloc_item(16);
        alloc_item(17);
        alloc_item(100);
        free_item(4095);
        free_item(8);
        free_item(48);
        free_item(0);
        free_item(0);
        free_item(16);
        free_item(32);
        alloc_item(4096);
        alloc_item(1);
        free_item(0);
        alloc_item(2048);
        alloc_item(2048);
        alloc_item(2049);
        free_item(2048);
        free_item(0);
        alloc_item(4095);
        free_item(0);
    endtask

    task automatic test_random(input int count);
        int sel;
        int idx;
        repeat (count)
        begin
            sel = int'($urandom_range(99));
            if (sel < 45)
            begin
                if ($urandom_range(9) < 7)
                    alloc_item(int'($urandom_range(1, 256)));
                else
                    alloc_item(int'($urandom_range(8191)));
            end
            else if (sel < 90 && owned_q.size() > 0)
            begin
                idx = int'($urandom_range(owned_q.size() - 1));
                free_item(int'(owned_q[idx]));
            end
            else
            begin
                free_item(int'($urandom_range(4095)));
            end
        end
    endtask

    task automatic test_release_all();
        while (owned_q.size() > 0)
            free_item(int'(owned_q[0]));
    endtask

    task automatic drain_all();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        tree_free[1] = 1'b1;
        used_bytes = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        idle_pct = 12;
        test_random(340);
        idle_pct = 58;
        test_random(340);
        idle_pct = 0;
        test_random(340);
        test_release_all();
        drain_all();
        $display("Sent %0d items with %0d results, covering fails, bad frees and merges",
            items_sent, results_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// ===== buddy_block_allocator.f =====
hw/rtl/bba_pkg.sv
hw/rtl/buddy_block_allocator.sv
sim/tb_buddy_block_allocator.sv
